/* hw/rtl/spts_pkg.sv */
// Shared types and constants of the sparse polynomial term store.
package spts_pkg;

    localparam int MAX_TERMS = 32;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int COEF_W    = 32;
    localparam int DEG_W     = 16;
    localparam int DATA_W    = COEF_W + DEG_W;

    typedef enum logic [1:0] {
        OP_INS_A = 2'd0,
        OP_INS_B = 2'd1,
        OP_SUM   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_TERM  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ADD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_FROM_HEAD
    } cell_op_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [DEG_W-1:0]         deg;
    } term_t;

    // commands from the sequencer to one term chain
    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
    } chain_ctrl_t;

    // what one term chain reports back
    typedef struct packed {
        term_t            head;
        logic [CNT_W-1:0] count;
        logic             drop;
    } chain_stat_t;

endpackage

/* hw/rtl/spts_cell.sv */
// One term slot of a chain: holds a term, compares it with the incoming degree.
module spts_cell
    import spts_pkg::*;
(
    input  logic     clk,
    input  cell_op_t op,
    input  logic     valid,
    input  term_t    ins,
    input  term_t    prev,
    input  term_t    next,
    input  term_t    head,
    output term_t    term,
    output logic     gt,
    output logic     eq
);

    term_t term_reg;
    term_t term_next;

    assign term = term_reg;
    assign gt   = valid && (term_reg.deg > ins.deg);
    assign eq   = valid && (term_reg.deg == ins.deg);

    always_comb
    begin
        term_next = term_reg;
        case (op)
            CELL_HOLD:      term_next = term_reg;
            CELL_ADD:       term_next.coef = term_reg.coef + ins.coef;  // wraps mod 2^32
            CELL_LOAD:      term_next = ins;
            CELL_FROM_PREV: term_next = prev;
            CELL_FROM_NEXT: term_next = next;
            CELL_FROM_HEAD: term_next = head;
            default:        term_next = term_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
    end

endmodule

/* hw/rtl/spts_chain.sv */
// Row of term cells for one polynomial, kept in descending degree order.
module spts_chain
    import spts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctrl_t ctrl,
    input  term_t       ins,
    output chain_stat_t stat
);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    term_t                cell_term [MAX_TERMS];
    logic [MAX_TERMS-1:0] gt;
    logic [MAX_TERMS-1:0] eq;
    logic                 any_eq;
    logic                 full;

    assign any_eq = |eq;
    assign full   = (count_reg == CNT_W'(MAX_TERMS));

    assign stat.head  = cell_term[0];
    assign stat.count = count_reg;
    assign stat.drop  = full && !any_eq;

    genvar i;
    generate
        for (i = 0; i < MAX_TERMS; i++)
        begin : g_cell
            term_t    prev_term;
            term_t    next_term;
            logic     first_slot;
            logic     valid;
            cell_op_t op;

            if (i == 0)
            begin : g_first
                assign prev_term  = ins;
                assign first_slot = 1'b1;
            end
            else
            begin : g_mid
                assign prev_term  = cell_term[i-1];
                assign first_slot = gt[i-1];
            end

            if (i == MAX_TERMS - 1)
            begin : g_last
                assign next_term = cell_term[i];
            end
            else
            begin : g_notlast
                assign next_term = cell_term[i+1];
            end

            assign valid = (CNT_W'(i) < count_reg);

            always_comb
            begin
                op = CELL_HOLD;
                if (ctrl.insert)
                begin
                    if (any_eq)
                        op = eq[i] ? CELL_ADD : CELL_HOLD;
                    else if (full || gt[i])
                        op = CELL_HOLD;
                    else if (first_slot)
                        op = CELL_LOAD;
                    else
                        op = CELL_FROM_PREV;
                end
                else if (ctrl.pop)
                begin
                    // rotate the live terms one place toward the head
                    if (CNT_W'(i + 1) < count_reg)
                        op = CELL_FROM_NEXT;
                    else if (CNT_W'(i + 1) == count_reg)
                        op = CELL_FROM_HEAD;
                    else
                        op = CELL_HOLD;
                end
            end

            spts_cell u_cell (
                .clk   (clk),
                .op    (op),
                .valid (valid),
                .ins   (ins),
                .prev  (prev_term),
                .next  (next_term),
                .head  (cell_term[0]),
                .term  (cell_term[i]),
                .gt    (gt[i]),
                .eq    (eq[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
            count_next = '0;
        else if (ctrl.insert && !any_eq && !full)
            count_next = count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

/* hw/rtl/sparse_polynomial_term_store.sv */
// Top level: two sorted term chains, a command sequencer and the result register.
//
//  channel | dir | tdata (low bit up)              | tuser   | tlast
//  --------+-----+---------------------------------+---------+---------------
//  s_*     | in  | coefficient[31:0], degree[47:32] | op[1:0] | -
//  m_*     | out | term_coefficient[31:0],          | status  | last result of
//          |     | term_degree[47:32]              | [1:0]   | the input word
//
// An insert is accepted, then the cell row does one shift/add step. A sum
// merges the heads: each chain pops at most one head per cycle while the
// result register is free, and rotates it to its tail, so the tables are
// intact afterwards. A clear is done on acceptance.
// Reset clears both term counts and the sequencer; term cells are not reset.
// A stall on m_tready holds the result register and freezes the insert and
// sum states; s_tready is high only while no word is in progress.
module sparse_polynomial_term_store
    import spts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // coefficient, degree
    input  logic [1:0]        s_tuser,   // op
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // term_coefficient, term_degree
    output logic [1:0]        m_tuser,   // status
    output logic              m_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_SUM
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    term_t               cmd_reg;
    logic [CNT_W-1:0]    rem_a_reg;
    logic [CNT_W-1:0]    rem_b_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    term_t               out_term_reg;
    logic                out_last_reg;

    chain_ctrl_t         ctrl_a;
    chain_ctrl_t         ctrl_b;
    chain_stat_t         stat_a;
    chain_stat_t         stat_b;
    term_t               in_term;
    op_t                 in_op;
    logic                in_fire;
    logic                out_free;

    // merge decision on the two chain heads
    logic                ra_nz;
    logic                rb_nz;
    logic                take_both;
    logic                take_a;
    logic                take_b;
    logic [CNT_W-1:0]    rem_a_next;
    logic [CNT_W-1:0]    rem_b_next;
    term_t               merge_term;

    assign in_term.coef = s_tdata[COEF_W-1:0];
    assign in_term.deg  = s_tdata[DATA_W-1:COEF_W];
    assign in_op        = op_t'(s_tuser);

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_term_reg.deg, out_term_reg.coef};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign ra_nz     = (rem_a_reg != '0);
    assign rb_nz     = (rem_b_reg != '0);
    assign take_both = ra_nz && rb_nz && (stat_a.head.deg == stat_b.head.deg);
    assign take_a    = !take_both && ra_nz && (!rb_nz || stat_a.head.deg > stat_b.head.deg);
    assign take_b    = !take_both && !take_a && rb_nz;

    assign rem_a_next = rem_a_reg - CNT_W'(take_both || take_a);
    assign rem_b_next = rem_b_reg - CNT_W'(take_both || take_b);

    always_comb
    begin
        merge_term = stat_b.head;
        if (take_both)
        begin
            merge_term.coef = stat_a.head.coef + stat_b.head.coef;
            merge_term.deg  = stat_a.head.deg;
        end
        else if (take_a)
            merge_term = stat_a.head;
    end

    // chain commands
    always_comb
    begin
        ctrl_a = '0;
        ctrl_b = '0;
        if (in_fire && in_op == OP_CLEAR)
        begin
            ctrl_a.clear = 1'b1;
            ctrl_b.clear = 1'b1;
        end
        if (state_reg == S_INSERT && out_free)
        begin
            ctrl_a.insert = (op_reg == OP_INS_A);
            ctrl_b.insert = (op_reg == OP_INS_B);
        end
        if (state_reg == S_SUM && out_free)
        begin
            ctrl_a.pop = take_both || take_a;
            ctrl_b.pop = take_both || take_b;
        end
    end

    spts_chain u_chain_a (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl_a),
        .ins   (cmd_reg),
        .stat  (stat_a)
    );

    spts_chain u_chain_b (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl_b),
        .ins   (cmd_reg),
        .stat  (stat_b)
    );

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (m_tready)
                        out_valid_reg <= 1'b0;
                    if (in_fire)
                    begin
                        if (in_op == OP_INS_A || in_op == OP_INS_B)
                            state_reg <= S_INSERT;
                        else if (in_op == OP_SUM)
                            state_reg <= S_SUM;
                    end
                end
                S_INSERT:
                begin
                    // a waiting result without m_tready keeps valid high
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_SUM:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (rem_a_next == '0 && rem_b_next == '0)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    out_valid_reg <= 1'b0;
                    state_reg     <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= in_op;
            cmd_reg   <= in_term;
            rem_a_reg <= stat_a.count;
            rem_b_reg <= stat_b.count;
        end
        if (state_reg == S_INSERT && out_free)
        begin
            out_status_reg <= (op_reg == OP_INS_A ? stat_a.drop : stat_b.drop)
                              ? ST_FULL : ST_DONE;
            out_term_reg   <= '0;
            out_last_reg   <= 1'b1;
        end
        if (state_reg == S_SUM && out_free)
        begin
            rem_a_reg    <= rem_a_next;
            rem_b_reg    <= rem_b_next;
            out_last_reg <= (rem_a_next == '0) && (rem_b_next == '0);
            if (!ra_nz && !rb_nz)
            begin
                // both tables empty
                out_status_reg <= ST_EMPTY;
                out_term_reg   <= '0;
            end
            else
            begin
                out_status_reg <= ST_TERM;
                out_term_reg   <= merge_term;
            end
        end
    end

endmodule

/* tb/tb_sparse_polynomial_term_store.sv */
// Self-checking testbench for the sparse polynomial term store.
module tb_sparse_polynomial_term_store;
    import spts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 16;

    // one command word waiting to be sent
    typedef struct {
        op_t         op;
        logic [31:0] coef;
        logic [15:0] deg;
        bit          drain_first;  // hold it back until every reply is in
    } cmd_t;

    // one reply word as the store should send it
    typedef struct {
        status_t     status;
        logic [31:0] coef;
        logic [15:0] deg;
        logic        last;
    } reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;   // coefficient, degree
    logic [1:0]        s_tuser = '0;   // op
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;        // term_coefficient, term_degree
    logic [1:0]        m_tuser;        // status
    logic              m_tlast;

    sparse_polynomial_term_store dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    cmd_t   cmd_queue[$];
    reply_t exp_replies[$];
    cmd_t   cmd_out;

    // Our own copy of both term tables; index 0 is A, 1 is B.
    logic [31:0] tab_coef [2][MAX_TERMS];
    logic [15:0] tab_deg  [2][MAX_TERMS];
    int          tab_len  [2];

    int send_idle_pct = 28;
    int recv_idle_pct = 69;
    int n_accepted    = 0;
    int n_errors      = 0;
    int n_cycles      = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Insert or accumulate one term; tables stay sorted by falling degree.
    function automatic status_t insert_term(input int p, input logic [31:0] c,
                                            input logic [15:0] d);
        int pos;
        int j;
        pos = 0;
        while (pos < tab_len[p] && tab_deg[p][pos] > d)
            pos++;
        if (pos < tab_len[p] && tab_deg[p][pos] == d)
        begin
            tab_coef[p][pos] += c;   // matching degree adds even when full
            return ST_DONE;
        end
        if (tab_len[p] >= MAX_TERMS)
            return ST_FULL;
        for (j = tab_len[p]; j > pos; j--)
        begin
            tab_coef[p][j] = tab_coef[p][j-1];
            tab_deg[p][j]  = tab_deg[p][j-1];
        end
        tab_coef[p][pos] = c;
        tab_deg[p][pos]  = d;
        tab_len[p]++;
        return ST_DONE;
    endfunction

    // Apply one accepted word to the tables and queue the replies it causes.
    task automatic poly_apply(input cmd_t w);
        int      i;
        int      j;
        reply_t  r;
        i = 0;
        j = 0;
        case (w.op)
            OP_INS_A: exp_replies.push_back('{insert_term(0, w.coef, w.deg), '0, '0, 1'b1});
            OP_INS_B: exp_replies.push_back('{insert_term(1, w.coef, w.deg), '0, '0, 1'b1});
            OP_SUM:
            begin
                if (tab_len[0] == 0 && tab_len[1] == 0)
                    exp_replies.push_back('{ST_EMPTY, '0, '0, 1'b1});
                while (i < tab_len[0] || j < tab_len[1])
                begin
                    r.status = ST_TERM;
                    if (i < tab_len[0] && j < tab_len[1] && tab_deg[0][i] == tab_deg[1][j])
                    begin
                        r.coef = tab_coef[0][i] + tab_coef[1][j];
                        r.deg  = tab_deg[0][i];
                        i++;
                        j++;
                    end
                    else if (j >= tab_len[1] ||
                             (i < tab_len[0] && tab_deg[0][i] > tab_deg[1][j]))
                    begin
                        r.coef = tab_coef[0][i];
                        r.deg  = tab_deg[0][i];
                        i++;
                    end
                    else
                    begin
                        r.coef = tab_coef[1][j];
                        r.deg  = tab_deg[1][j];
                        j++;
                    end
                    r.last = (i >= tab_len[0] && j >= tab_len[1]);
                    exp_replies.push_back(r);
                end
            end
            OP_CLEAR:
            begin
                tab_len[0] = 0;
                tab_len[1] = 0;
            end
        endcase
    endtask

    // Coefficients lean toward the extremes and small values so wraps and zero sums show up.
    function automatic logic [31:0] pick_coef();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return '0;
            4, 5:    return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_cmd(input op_t op, input logic [31:0] c, input logic [15:0] d,
                             input bit drain);
        cmd_queue.push_back('{op, c, d, drain});
    endtask

    // Sender: presents one word at a time, holds it until taken, and
    // predicts the replies at the edge where the word is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                poly_apply(cmd_out);
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct &&
                    !(cmd_queue[0].drain_first && exp_replies.size() != 0))
                begin
                    cmd_out = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cmd_out.deg, cmd_out.coef};
                    s_tuser  <= cmd_out.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure; every accepted word is checked
    // against the oldest predicted reply.
    always @(posedge clk or negedge rst_n)
    begin : reply_check
        reply_t e;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (exp_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply status=%0d coef=%0d deg=%0d last=%0d",
                             $time, m_tuser, $signed(m_tdata[31:0]), m_tdata[47:32], m_tlast);
                    n_errors++;
                end
                else
                begin
                    e = exp_replies.pop_front();
                    if (m_tuser != e.status || m_tdata[31:0] != e.coef ||
                        m_tdata[47:32] != e.deg || m_tlast != e.last)
                    begin
                        $display({"%0t: mismatch expected status=%0d coef=%0d deg=%0d ",
                                  "last=%0d, got status=%0d coef=%0d deg=%0d last=%0d"},
                                 $time, e.status, $signed(e.coef), e.deg, e.last,
                                 m_tuser, $signed(m_tdata[31:0]), m_tdata[47:32], m_tlast);
                        n_errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("** sparse_polynomial_term_store: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int total;
        int pick;
        int sel;
        int stride;
        int base;
        int odd;
        int off;
        int sh;
        int n;
        int k;
        int t;
        bit wide;
        logic [15:0] d;

        tab_len[0] = 0;
        tab_len[1] = 0;

        // Directed: empty sums, wrap on accumulate, zero terms kept,
        // equal-degree merge, one-sided sums, clear, toggling patterns.
        queue_cmd(OP_SUM,   $urandom,      16'($urandom), 1'b0);
        queue_cmd(OP_CLEAR, $urandom,      16'($urandom), 1'b0);
        queue_cmd(OP_SUM,   $urandom,      16'($urandom), 1'b0);
        queue_cmd(OP_INS_A, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        queue_cmd(OP_INS_A, 32'h0000_0001, 16'hFFFF, 1'b0);
        queue_cmd(OP_INS_A, 32'h8000_0000, 16'h0000, 1'b0);
        queue_cmd(OP_INS_A, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        queue_cmd(OP_INS_A, 32'd5,         16'd300,  1'b0);
        queue_cmd(OP_INS_B, 32'd0,         16'hFFFF, 1'b0);
        queue_cmd(OP_INS_B, 32'h5555_5555, 16'h5555, 1'b0);
        queue_cmd(OP_INS_B, 32'hAAAA_AAAA, 16'hAAAA, 1'b0);
        queue_cmd(OP_INS_B, -32'sd5,       16'd300,  1'b0);
        queue_cmd(OP_INS_B, 32'd7,         16'd1,    1'b0);
        queue_cmd(OP_SUM,   $urandom,      16'($urandom), 1'b0);
        queue_cmd(OP_CLEAR, $urandom,      16'($urandom), 1'b0);
        queue_cmd(OP_SUM,   $urandom,      16'($urandom), 1'b0);
        queue_cmd(OP_INS_B, 32'd9,         16'd42,   1'b0);
        queue_cmd(OP_SUM,   $urandom,      16'($urandom), 1'b0);
        queue_cmd(OP_CLEAR, $urandom,      16'($urandom), 1'b0);
        queue_cmd(OP_INS_A, 32'd3,         16'd7,    1'b0);
        queue_cmd(OP_SUM,   $urandom,      16'($urandom), 1'b0);
        queue_cmd(OP_INS_A, -32'sd3,       16'd7,    1'b0);
        queue_cmd(OP_SUM,   $urandom,      16'($urandom), 1'b0);
        // first random word waits for a fully drained store
        queue_cmd(OP_CLEAR, $urandom,      16'($urandom), 1'b1);

        while (cmd_queue.size() < 420)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                // noise: anything at all, including bare sums and clears
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    queue_cmd(op_t'($urandom_range(3)), $urandom, 16'($urandom), 1'b0);
            end
            else if (pick < 27)
            begin
                // Fill one or both tables to capacity with a permuted degree
                // order, then hit the full table with fresh and known degrees.
                sel    = $urandom_range(2);
                stride = $urandom_range(1, 3);
                sh     = $urandom_range(0, stride - 1);
                base   = $urandom_range(0, 65535 - 40 * 3);
                odd    = 2 * $urandom_range(0, 15) + 1;
                off    = $urandom_range(31);
                queue_cmd(OP_CLEAR, $urandom, 16'($urandom), $urandom_range(9) == 0);
                for (k = 0; k < MAX_TERMS; k++)
                    for (t = 0; t < 2; t++)
                        if (sel == 2 || sel == t)
                        begin
                            d = 16'(base + ((k * odd + off) % MAX_TERMS) * stride
                                    + (t ? sh : 0));
                            queue_cmd(t ? OP_INS_B : OP_INS_A, pick_coef(), d, 1'b0);
                        end
                n = $urandom_range(3, 6);
                for (k = 0; k < n; k++)
                    for (t = 0; t < 2; t++)
                        if (sel == 2 || sel == t)
                        begin
                            if ($urandom_range(1))
                                d = 16'(base + $urandom_range(31) * stride + (t ? sh : 0));
                            else
                                d = 16'(base + (MAX_TERMS + $urandom_range(3)) * stride
                                        + (t ? sh : 0));
                            queue_cmd(t ? OP_INS_B : OP_INS_A, pick_coef(), d, 1'b0);
                        end
                queue_cmd(OP_SUM, $urandom, 16'($urandom), 1'b0);
            end
            else
            begin
                // short build-and-sum; narrow degrees collide, wide ones spread
                if ($urandom_range(3) != 0)
                    queue_cmd(OP_CLEAR, $urandom, 16'($urandom), $urandom_range(9) == 0);
                n    = $urandom_range(1, 12);
                wide = ($urandom_range(3) == 0);
                for (k = 0; k < n; k++)
                begin
                    d = wide ? 16'($urandom) : 16'($urandom_range(0, 15));
                    queue_cmd($urandom_range(1) ? OP_INS_B : OP_INS_A, pick_coef(), d, 1'b0);
                end
                queue_cmd(OP_SUM, $urandom, 16'($urandom), 1'b0);
                if ($urandom_range(3) == 0)
                    queue_cmd(OP_SUM, $urandom, 16'($urandom), 1'b0);
            end
        end
        total = cmd_queue.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Idle mix: sender-light/receiver-heavy, then swapped, then none.
        while (n_accepted < total / 3)
            @(posedge clk);
        send_idle_pct = 69;
        recv_idle_pct = 28;
        while (n_accepted < 2 * total / 3)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        while (n_accepted < total || exp_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0 && exp_replies.size() == 0)
            $display("** sparse_polynomial_term_store: PASSED **");
        else
            $display("** sparse_polynomial_term_store: FAILED **");
        $finish;
    end

endmodule
